// ----- rtl/dsr_pkg.sv -----
`default_nettype none
package dsr_pkg;

  localparam int MAX_ELEMS = 64;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 37;
  localparam int OUT_TDATA_W = ((VAL_W + SUM_W + 7) / 8) * 8;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
  } cell_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/descending_sorter_with_even_sum.sv -----
// Descending insertion sorter with a running sum of positive even values.
// Input stream: in_tdata carries one signed 32-bit value per beat, in_tlast
// closes the set. Each accepted beat is inserted, unless the row is full, into a
// row of MAX_ELEMS compare-and-shift cells, one beat per cycle while loading.
// After the closing beat the block drains: out_tdata carries the values
// largest first, one beat per cycle unless stalled, with out_tlast on the final one.
// Every output beat carries the sum of the stored positive even values and
// out_tuser, set if any beat of the set found the row full and was dropped.
// The first result appears the cycle after the closing beat is accepted.
// in_tready is low during the drain, which is set by the single shift-out
// path of the cell row. The block returns to loading the cycle after the
// last output beat is taken.
// When the receiver holds out_tready low the row freezes and the current
// beat stays on the outputs.
// Reset (rst_n low, synchronous) empties the row and clears sum and flag.
`default_nettype none
module descending_sorter_with_even_sum (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [dsr_pkg::VAL_W-1:0]         in_tdata,   // value
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [dsr_pkg::OUT_TDATA_W-1:0]        out_tdata,  // sorted_value, even_sum
  output logic                                   out_tlast,
  output logic                                   out_tuser   // dropped
);
  import dsr_pkg::*;

  state_t               state_r, state_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 drop_r, drop_nxt;
  cell_t                cells [MAX_ELEMS];
  logic                 keeps [MAX_ELEMS];
  cell_ctl_t            ctl;
  logic                 in_beat, out_beat, full, even_pos;
  logic signed [VAL_W-1:0] new_value;

  assign new_value = $signed(in_tdata);
  assign in_tready = (state_r == ST_LOAD);
  assign in_beat   = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_DRAIN) && cells[0].valid;
  assign out_beat  = out_tvalid && out_tready;
  assign full      = cells[MAX_ELEMS-1].valid;
  assign even_pos  = !in_tdata[VAL_W-1] && !in_tdata[0] && (in_tdata != '0);

  assign ctl.ins   = in_beat && !full;
  assign ctl.shift = out_beat;

  assign out_tdata = {{(OUT_TDATA_W-VAL_W-SUM_W){1'b0}}, sum_r, cells[0].value};
  assign out_tlast = !cells[1].valid;
  assign out_tuser = drop_r;

  genvar g;
  generate
    for (g = 0; g < MAX_ELEMS; g++) begin : g_cell
      cell_t prev_c, next_c;
      logic  prev_k;
      if (g == 0) begin : g_first
        assign prev_c = '{valid: 1'b0, value: '0};
        assign prev_k = 1'b1;
      end else begin : g_mid
        assign prev_c = cells[g-1];
        assign prev_k = keeps[g-1];
      end
      if (g == MAX_ELEMS-1) begin : g_end
        assign next_c = '{valid: 1'b0, value: '0};
      end else begin : g_body
        assign next_c = cells[g+1];
      end
      dsr_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_value (new_value),
        .prev_keep (prev_k),
        .prev_cell (prev_c),
        .next_cell (next_c),
        .slot      (cells[g]),
        .keep      (keeps[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_beat) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else if (even_pos) begin
            sum_nxt = sum_r + SUM_W'(in_tdata);
          end
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_beat && out_tlast) begin
          state_nxt = ST_LOAD;
          sum_nxt   = '0;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      sum_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      drop_r  <= drop_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken during drain");

  a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> out_tvalid)
    else $error("drain with empty row");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_tlast) |=> (in_tready && !cells[0].valid && sum_r == '0 && !drop_r))
    else $error("row or sum not cleared after last beat");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!cells[0].valid) |-> (sum_r == '0 && !drop_r))
    else $error("sum or flag set with empty row");
`endif

endmodule
`default_nettype wire

// ----- rtl/dsr_cell.sv -----
`default_nettype none
module dsr_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire dsr_pkg::cell_ctl_t              ctl,
  input  wire logic signed [dsr_pkg::VAL_W-1:0] new_value,
  input  wire logic                            prev_keep,
  input  wire dsr_pkg::cell_t                  prev_cell,
  input  wire dsr_pkg::cell_t                  next_cell,
  output dsr_pkg::cell_t                       slot,
  output logic                                 keep
);
  import dsr_pkg::*;

  logic  valid_r, valid_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;

  assign keep = valid_r && (value_r >= new_value);
  assign slot = '{valid: valid_r, value: value_r};

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctl.ins && !keep) begin
      if (prev_keep) begin
        valid_nxt = 1'b1;
        value_nxt = new_value;
      end else begin
        valid_nxt = prev_cell.valid;
        value_nxt = prev_cell.value;
      end
    end else if (ctl.shift) begin
      valid_nxt = next_cell.valid;
      value_nxt = next_cell.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ----- bench/tb_descending_sorter_with_even_sum.sv -----
`timescale 1ns / 1ps
module tb_descending_sorter_with_even_sum;
  import dsr_pkg::*;

  localparam int PAD_LO = VAL_W + SUM_W;

  typedef logic signed [VAL_W-1:0] elem_t;

  typedef struct {
    elem_t            value;
    logic [SUM_W-1:0] even_sum;
    logic             last;
    logic             dropped;
  } sorted_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  wire                    in_tready;
  logic [VAL_W-1:0]       in_tdata = '0;
  logic                   in_tlast = 1'b0;
  wire                    out_tvalid;
  logic                   out_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] out_tdata;
  wire                    out_tlast;
  wire                    out_tuser;

  elem_t            set_vals[$];
  logic [SUM_W-1:0] set_even_sum = '0;
  logic             set_dropped = 1'b0;
  sorted_beat_t     sorted_due[$];

  int fail_cnt = 0;
  int beat_gap_pct = 0;
  int ready_drop_pct = 0;
  int ready_hold_cycles = 0;

  descending_sorter_with_even_sum i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Insert into the descending set, or flag a drop when it is full; on the closing beat queue the whole set.
  function automatic void absorb_element(elem_t v, logic last);
    int pos;
    sorted_beat_t b;
    if (set_vals.size() < MAX_ELEMS) begin
      pos = 0;
      while (pos < set_vals.size() && set_vals[pos] >= v) pos++;
      set_vals.insert(pos, v);
      if (v > 0 && !v[0]) set_even_sum += {{(SUM_W-VAL_W){1'b0}}, v};
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      foreach (set_vals[i]) begin
        b.value    = set_vals[i];
        b.even_sum = set_even_sum;
        b.last     = (i == set_vals.size() - 1);
        b.dropped  = set_dropped;
        sorted_due.push_back(b);
      end
      set_vals.delete();
      set_even_sum = '0;
      set_dropped  = 1'b0;
    end
  endfunction

  function automatic elem_t rand_element();
    elem_t r;
    case ($urandom_range(0, 4))
      0: r = elem_t'($urandom_range(0, 40)) - 20;
      1: begin
        r = $urandom;
        r[VAL_W-1] = 1'b0;
        r[0] = 1'b0;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: r = 32'h7FFF_FFFF;
          1: r = 32'h8000_0000;
          2: r = 32'h7FFF_FFFE;
          default: r = '0;
        endcase
      end
      default: r = $urandom;
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    sorted_beat_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_due.size() == 0) begin
        fail_cnt++;
        $display("%0t unexpected beat: expected none, actual data %h last %b user %b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        exp_b = sorted_due.pop_front();
        check_field("sorted_value", SUM_W'(unsigned'(exp_b.value)),
                    SUM_W'(out_tdata[VAL_W-1:0]));
        check_field("even_sum", exp_b.even_sum, out_tdata[PAD_LO-1:VAL_W]);
        check_field("pad", '0, SUM_W'(out_tdata[OUT_TDATA_W-1:PAD_LO]));
        check_field("last", SUM_W'(exp_b.last), SUM_W'(out_tlast));
        check_field("dropped", SUM_W'(exp_b.dropped), SUM_W'(out_tuser));
      end
    end
  end

  // Hold off for the requested stretch, else stall at random.
  always @(posedge clk) begin
    if (ready_hold_cycles > 0) begin
      out_tready <= 1'b0;
      ready_hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= ready_drop_pct);
    end
  end

  task automatic send_beat(input elem_t v, input logic last);
    while ($urandom_range(0, 99) < beat_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_element(v, last);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sorted_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_sets(input int n_items);
    int sent;
    int size;
    sent = 0;
    while (sent < n_items) begin
      size = $urandom_range(1, 8);
      for (int k = 0; k < size; k++) send_beat(rand_element(), k == size - 1);
      sent += size;
    end
    end_burst();
  endtask

  task automatic test_small_sets();
    send_beat(32'h8000_0000, 1'b1);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(0, 1'b0);
    send_beat(2, 1'b0);
    send_beat(-2, 1'b0);
    send_beat(3, 1'b0);
    send_beat(32'h7FFF_FFFE, 1'b1);
    send_beat(5, 1'b0);
    send_beat(5, 1'b0);
    send_beat(-7, 1'b0);
    send_beat(-7, 1'b0);
    send_beat(4, 1'b0);
    send_beat(4, 1'b1);
    end_burst();
  endtask

  // Fill the row with the largest even value, then overrun it and close on a dropped beat.
  task automatic test_capacity();
    for (int k = 0; k < MAX_ELEMS; k++) send_beat(32'h7FFF_FFFE, 1'b0);
    for (int k = 0; k < 2; k++) send_beat(rand_element(), k == 1);
    end_burst();
  endtask

  task automatic test_idle_mix();
    beat_gap_pct = 0;  ready_drop_pct = 0;  random_sets(6);
    beat_gap_pct = 76; ready_drop_pct = 0;  random_sets(6);
    beat_gap_pct = 0;  ready_drop_pct = 76; random_sets(6);
    beat_gap_pct = 35; ready_drop_pct = 35; random_sets(6);
    wait_drained();
  endtask

  task automatic test_backpressure();
    beat_gap_pct = 0;
    ready_drop_pct = 0;
    ready_hold_cycles = 300;
    random_sets(10);
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_sets();
    test_capacity();
    test_idle_mix();
    test_backpressure();
    wait_drained();
    repeat (2 * MAX_ELEMS + 10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dsr_pkg.sv
rtl/dsr_cell.sv
rtl/descending_sorter_with_even_sum.sv
bench/tb_descending_sorter_with_even_sum.sv
